// File: rtl/running_variance_stddev_macros.svh
// Assertion macros shared by the running variance block
`ifndef RUNNING_VARIANCE_STDDEV_MACROS_SVH
`define RUNNING_VARIANCE_STDDEV_MACROS_SVH
// assert that a implies b on the same edge
`define RVS_ASSERT_IMP(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("rvs: %s", "label");
// assert that a implies b on the next edge
`define RVS_ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("rvs: %s", "label");
`endif

// File: rtl/rvs_pkg.sv
// Types and constants of the running variance block
`default_nettype none
package rvs_pkg;
  typedef enum logic [1:0] {
    KS_NONE = 2'd0, KS_FAILED = 2'd1, KS_DUR = 2'd2, KS_NUM = 2'd3
  } kind_e;

  localparam logic [2:0] VK_NULL_ARRAY = 3'd0;
  localparam logic [2:0] VK_NUMBER     = 3'd1;
  localparam logic [2:0] VK_NUM_NULL   = 3'd2;
  localparam logic [2:0] VK_DURATION   = 3'd3;

  // work item from the front end to the arithmetic back end
  typedef struct packed {
    logic        acc;      // accumulate the sample
    logic        clear;    // zero the accumulators
    logic        is_valid; // form a result value
    logic        is_dur;
    logic        failed;
    logic        mode;
    logic [31:0] count;    // reported count
    logic [47:0] divisor;  // new count
    logic signed [23:0] sample;
  } job_t;
endpackage
`default_nettype wire

// File: rtl/rvs_front.sv
// Front end: classify items, track kind and count, emit jobs
`default_nettype none
module rvs_front
  import rvs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        mode_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        clear_i,
  input  wire logic [2:0]  value_kind_i,
  input  wire logic signed [23:0] sample_i,
  output logic             job_valid_o,
  input  wire logic        job_ready_i,
  output job_t             job_o
);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  kind_e kind_q, kind_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic acc;
  logic signed [23:0] sx;

  assign full = job_valid_o && !job_ready_i;
  assign sx = 24'(signed'(sample_i[SAMPLE_WIDTH-1:0]));

  always_comb begin
    kind_d = kind_q;
    cnt_d  = cnt_q;
    acc    = 1'b0;
    if (clear_i) begin
      kind_d = KS_NONE;
      cnt_d  = '0;
    end else if (kind_q != KS_FAILED) begin
      case (value_kind_i)
        VK_NULL_ARRAY: ;
        VK_NUMBER, VK_NUM_NULL: begin
          if (kind_q != KS_NUM && kind_q != KS_NONE) kind_d = KS_FAILED;
          else begin
            kind_d = KS_NUM;
            acc = (value_kind_i == VK_NUMBER);
          end
        end
        VK_DURATION: begin
          if ((kind_q != KS_DUR && kind_q != KS_NONE) || mode_i) kind_d = KS_FAILED;
          else begin
            kind_d = KS_DUR;
            acc = 1'b1;
          end
        end
        default: kind_d = KS_FAILED;
      endcase
      if (acc && cnt_q != CountMax) cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KS_NONE;
      cnt_q <= '0;
      job_valid_o <= 1'b0;
    end else begin
      if (push && !full) begin
        kind_q <= kind_d;
        cnt_q <= cnt_d;
        job_valid_o <= 1'b1;
      end else if (job_ready_i) begin
        job_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      job_o.acc      <= acc;
      job_o.clear    <= clear_i;
      job_o.is_valid <= (cnt_d != '0) && (kind_d == KS_NUM || kind_d == KS_DUR);
      job_o.is_dur   <= kind_d == KS_DUR;
      job_o.failed   <= kind_d == KS_FAILED;
      job_o.mode     <= mode_i;
      job_o.count    <= (COUNT_WIDTH > 32 && (cnt_d >> 32) != '0) ? '1 : 32'(cnt_d);
      job_o.divisor  <= 48'(cnt_d);
      job_o.sample   <= sx;
    end
  end
endmodule
`default_nettype wire

// File: rtl/rvs_back.sv
// Back end: mean update, mean of squares update, variance and root
`default_nettype none
module rvs_back
  import rvs_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  wire job_t        job_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [61:0]      result_value_o,
  output logic             result_valid_o,
  output logic             result_is_duration_o,
  output logic             failed_o,
  output logic [31:0]      sample_count_o
);
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001, ST_DIV1 = 7'b0000010, ST_DIV2 = 7'b0000100,
    ST_MUL  = 7'b0001000, ST_SQRT = 7'b0010000, ST_OUT  = 7'b0100000,
    ST_PREP = 7'b1000000
  } st_e;

  st_e st_q;
  job_t job_q;
  logic signed [63:0] mean_q;
  logic [63:0] msq_q;
  // shared restoring divider / root unit
  logic [63:0] num_q, quo_q, rem_q;
  logic [81:0] rad_q;
  logic [63:0] root_q;
  logic [6:0] it_q;
  logic neg_q;
  logic [63:0] x2_q, var_q;
  logic [127:0] mm_q;
  logic [1:0] mph_q;
  logic signed [63:0] xs, diff;
  logic signed [47:0] sq_s;
  logic [64:0] rem_sh;
  logic [63:0] rt_sh, rt_trial;
  logic [63:0] p_ll, p_hl, p_hh;
  logic [63:0] mm_sc, var_n, vsel;
  logic out_fire;

  assign job_ready_o = (st_q == ST_IDLE);
  assign xs = 64'(signed'(job_q.sample)) <<< FRACTION_BITS;
  assign diff = xs - mean_q;
  assign sq_s = job_q.sample * job_q.sample;
  assign rem_sh = {rem_q, num_q[63]};
  // root step: bring down two radicand bits, try 4*root+1
  assign rt_sh = {rem_q[61:0], rad_q[81:80]};
  assign rt_trial = {root_q[61:0], 2'b01};
  assign p_ll = num_q[31:0] * num_q[31:0];
  assign p_hl = num_q[63:32] * num_q[31:0];
  assign p_hh = num_q[63:32] * num_q[63:32];
  assign mm_sc = 64'(mm_q >> FRACTION_BITS);
  assign var_n = (msq_q >= mm_sc) ? msq_q - mm_sc : '0;
  assign vsel = job_q.mode ? var_q : root_q;
  // hold the finished item until the result register is free
  assign out_fire = (st_q == ST_OUT) && (!res_valid_o || res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      res_valid_o <= 1'b0;
      mean_q <= '0;
      msq_q <= '0;
    end else begin
      if (out_fire) res_valid_o <= 1'b1;
      else if (res_ready_i) res_valid_o <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (job_valid_i) begin
          job_q <= job_i;
          st_q <= ST_PREP;
        end
        ST_PREP: begin
          if (job_q.clear) begin
            mean_q <= '0;
            msq_q <= '0;
            st_q <= ST_OUT;
          end else if (job_q.acc) begin
            neg_q <= diff < 0;
            num_q <= (diff < 0) ? 64'(-diff) : 64'(diff);
            x2_q <= 64'(sq_s) << FRACTION_BITS;
            rem_q <= '0; quo_q <= '0; it_q <= '0;
            st_q <= ST_DIV1;
          end else begin
            mph_q <= '0;
            st_q <= ST_MUL;
          end
        end
        ST_DIV1, ST_DIV2: begin
          if (it_q == 7'd64) begin
            it_q <= '0;
            if (st_q == ST_DIV1) begin
              mean_q <= neg_q ? mean_q - signed'(quo_q) : mean_q + signed'(quo_q);
              neg_q <= x2_q < msq_q;
              num_q <= (x2_q >= msq_q) ? x2_q - msq_q : msq_q - x2_q;
              rem_q <= '0; quo_q <= '0;
              st_q <= ST_DIV2;
            end else begin
              msq_q <= neg_q ? msq_q - quo_q : msq_q + quo_q;
              mph_q <= '0;
              st_q <= ST_MUL;
            end
          end else begin
            // one quotient bit per cycle
            num_q <= num_q << 1;
            if (rem_sh >= {17'd0, job_q.divisor}) begin
              rem_q <= 64'(rem_sh - {17'd0, job_q.divisor});
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
            it_q <= it_q + 1'b1;
          end
        end
        ST_MUL: begin
          // square the mean magnitude from its two 32-bit halves with three 32x32 products
          mph_q <= mph_q + 1'b1;
          if (mph_q == 2'd0) num_q <= mean_q < 0 ? 64'(-mean_q) : 64'(mean_q);
          else if (mph_q == 2'd1) mm_q <= 128'(p_ll) + (128'(p_hl) << 33);
          else begin
            mm_q <= mm_q + (128'(p_hh) << 64);
            st_q <= ST_SQRT;
            it_q <= 7'd41;
          end
        end
        ST_SQRT: begin
          if (it_q == 7'd41) begin
            var_q <= var_n;
            rad_q <= 82'(var_n) << FRACTION_BITS;
            root_q <= '0;
            rem_q <= '0;
            it_q <= 7'd40;
            if (job_q.mode) st_q <= ST_OUT;
          end else begin
            if (rt_sh >= rt_trial) begin
              rem_q <= rt_sh - rt_trial;
              root_q <= {root_q[62:0], 1'b1};
            end else begin
              rem_q <= rt_sh;
              root_q <= {root_q[62:0], 1'b0};
            end
            rad_q <= rad_q << 2;
            it_q <= it_q - 1'b1;
            if (it_q == 7'd0) st_q <= ST_OUT;
          end
        end
        ST_OUT: if (out_fire) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      result_valid_o <= job_q.is_valid;
      result_is_duration_o <= job_q.is_dur;
      failed_o <= job_q.failed;
      sample_count_o <= job_q.count;
      if (!job_q.is_valid || job_q.clear) result_value_o <= '0;
      else result_value_o <= ((vsel > 64'h3FFF_FFFF_FFFF_FFFF) ? 62'h3FFF_FFFF_FFFF_FFFF
                            : vsel[61:0]) & (job_q.is_dur ? ~62'((64'd1 << FRACTION_BITS) - 1)
                            : '1);
    end
  end
endmodule
`default_nettype wire

// File: rtl/running_variance_stddev.sv
// Top level of the running variance and standard deviation block
//
// Input queue: push with clear_i, value_kind_i, sample_i while full is low.
// Result queue: result fields stand while empty is low; pop takes the beat.
// The user must write the mode register by mode_we_i / mode_wdata_i only while idle; the block does not enforce this.
// The front end settles kind and count and registers a job for the back end,
// which runs two restoring divisions for an accumulated sample, a square of
// the mean for any item but a clear, and in standard deviation mode a
// digit-by-digit root, all on one shared sequencer. The back end takes a new
// item only once it has passed the last one to the result register.
// Reset clears kind, count, mean and mean of squares; mode returns to
// standard deviation. While the result is not popped the back end finishes
// the next item and holds it, and one more item waits in the front end
// before full rises.
`default_nettype none
module running_variance_stddev
  import rvs_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int FRACTION_BITS = 16,
  parameter int COUNT_WIDTH   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        mode_we_i,
  input  wire logic        mode_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        clear_i,
  input  wire logic [2:0]  value_kind_i,
  input  wire logic signed [23:0] sample_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [61:0]      result_value_o,
  output logic             result_valid_o,
  output logic             result_is_duration_o,
  output logic             failed_o,
  output logic [31:0]      sample_count_o
);
  logic mode_q;
  logic jv, jr, rv;
  job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (mode_we_i) mode_q <= mode_wdata_i;
  end

  rvs_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk_i, .rst_ni, .mode_i(mode_q), .push, .full, .clear_i, .value_kind_i,
    .sample_i, .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  rvs_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .res_valid_o(rv), .res_ready_i(pop), .result_value_o, .result_valid_o,
    .result_is_duration_o, .failed_o, .sample_count_o
  );

  assign empty = !rv;

  `include "running_variance_stddev_macros.svh"
  `RVS_ASSERT_IMP(a_dur_not_failed, clk_i, rst_ni, !empty, !(result_is_duration_o && failed_o))
  `RVS_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, !empty && !result_valid_o, result_value_o == '0)
  `RVS_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, !empty && !pop, !empty)
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the running variance and standard deviation block
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import rvs_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        mode_we_i = 1'b0;
  logic        mode_wdata_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        clear_i = 1'b0;
  logic [2:0]  value_kind_i = '0;
  logic signed [23:0] sample_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [61:0] result_value_o;
  logic        result_valid_o;
  logic        result_is_duration_o;
  logic        failed_o;
  logic [31:0] sample_count_o;

  always #2 clk_i = ~clk_i;

  running_variance_stddev dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .mode_we_i(mode_we_i), .mode_wdata_i(mode_wdata_i),
    .push(push), .full(full),
    .clear_i(clear_i), .value_kind_i(value_kind_i), .sample_i(sample_i),
    .empty(empty), .pop(pop),
    .result_value_o(result_value_o), .result_valid_o(result_valid_o),
    .result_is_duration_o(result_is_duration_o), .failed_o(failed_o),
    .sample_count_o(sample_count_o)
  );

  typedef struct packed {
    logic [61:0] value;
    logic        valid;
    logic        is_dur;
    logic        failed;
    logic [31:0] count;
  } stat_t;

  // Predictor state: a private copy of the block's accumulators
  logic               cur_mode;
  logic signed [39:0] mean_acc;
  logic [63:0]        meansq_acc;
  logic [31:0]        n_acc;
  kind_e              kind_acc;

  stat_t expected_stats[$];
  int    mismatches;
  int    results_seen;
  int    items_sent;
  int    idle_pct;      // idling chance per side, in percent
  bit    hold_quiet;
  int    stall_cycles = 0;

  function automatic logic [63:0] isqrt_scaled(input logic [63:0] v);
    logic [127:0] radicand;
    logic [63:0]  r, c;
    radicand = {64'd0, v} << 16;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= radicand) r = c;
    end
    return r;
  endfunction

  task automatic fold_sample(input logic signed [23:0] s);
    logic signed [63:0] x, xs, diff, m;
    logic [63:0]        x2, mag, n;
    x  = 64'(s);
    xs = x <<< 16;
    x2 = 64'(x * x) << 16;
    if (n_acc != 32'hFFFF_FFFF) n_acc = n_acc + 1;
    n = 64'(n_acc);
    m = 64'(mean_acc);
    diff = xs - m;
    mag = diff < 0 ? 64'(-diff) : 64'(diff);
    mag = mag / n;
    m = diff < 0 ? m - $signed(mag) : m + $signed(mag);
    mean_acc = m[39:0];
    if (x2 >= meansq_acc) meansq_acc = meansq_acc + (x2 - meansq_acc) / n;
    else meansq_acc = meansq_acc - (meansq_acc - x2) / n;
  endtask

  task automatic predict_stats(input logic clr, input logic [2:0] vk,
                               input logic signed [23:0] s);
    stat_t r;
    logic [63:0]  a, mm, var_q, v;
    logic [127:0] sq;
    if (clr) begin
      mean_acc = '0; meansq_acc = '0; n_acc = '0; kind_acc = KS_NONE;
    end else if (kind_acc != KS_FAILED) begin
      if (vk == VK_NUMBER || vk == VK_NUM_NULL) begin
        if (kind_acc != KS_NUM && kind_acc != KS_NONE) kind_acc = KS_FAILED;
        else begin
          kind_acc = KS_NUM;
          if (vk == VK_NUMBER) fold_sample(s);
        end
      end else if (vk == VK_DURATION) begin
        if ((kind_acc != KS_DUR && kind_acc != KS_NONE) || cur_mode) kind_acc = KS_FAILED;
        else begin
          kind_acc = KS_DUR;
          fold_sample(s);
        end
      end else if (vk != VK_NULL_ARRAY) begin
        kind_acc = KS_FAILED;
      end
    end
    r = '0;
    r.valid = n_acc != 0 && (kind_acc == KS_NUM || kind_acc == KS_DUR);
    if (r.valid) begin
      a = mean_acc < 0 ? 64'(-64'(mean_acc)) : 64'(mean_acc);
      sq = {64'd0, a} * {64'd0, a};
      mm = sq[79:16];
      var_q = meansq_acc >= mm ? meansq_acc - mm : 64'd0;
      v = cur_mode ? var_q : isqrt_scaled(var_q);
      if (v > {2'b00, {62{1'b1}}}) v = {2'b00, {62{1'b1}}};
      if (kind_acc == KS_DUR) v[15:0] = '0;
      r.value = v[61:0];
    end
    r.is_dur = kind_acc == KS_DUR;
    r.failed = kind_acc == KS_FAILED;
    r.count = n_acc;
    expected_stats.push_back(r);
  endtask

  // Send one item: hold push until the beat is taken, drop it only while idling
  task automatic send_item(input logic clr, input logic [2:0] vk,
                           input logic signed [23:0] s);
    while (!hold_quiet && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1; clear_i <= clr; value_kind_i <= vk; sample_i <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_stats(clr, vk, s);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    mode_we_i <= 1'b1; mode_wdata_i <= m;
    @(posedge clk_i);
    mode_we_i <= 1'b0;
    cur_mode = m;
  endtask

  // Result side: random pop stalls, compare each beat with the oldest prediction
  always @(posedge clk_i) begin
    stat_t got, want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got = '{result_value_o, result_valid_o, result_is_duration_o, failed_o,
                sample_count_o};
        results_seen++;
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = expected_stats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      pop <= hold_quiet || $urandom_range(99) >= idle_pct;
    end
  end

  // Watchdog: count cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic test_extremes();
    write_mode(1'b1);
    send_item(1'b0, VK_NUMBER, 24'sh7FFFFF);
    send_item(1'b0, VK_NUMBER, -24'sh800000);
    send_item(1'b0, VK_NUM_NULL, 24'sh000123);
    send_item(1'b0, VK_NULL_ARRAY, 24'sh000055);
    send_item(1'b0, VK_NUMBER, 24'sh0);
    write_mode(1'b0);
    send_item(1'b0, VK_NUMBER, 24'sh000003);
    send_item(1'b0, VK_DURATION, 24'sh000010);   // mixing kinds latches failure
    send_item(1'b0, VK_NUMBER, 24'sh000010);     // ignored while failed
    send_item(1'b1, 3'd0, 24'sh0);
    send_item(1'b0, VK_DURATION, 24'sh000100);
    send_item(1'b0, VK_DURATION, -24'sh000207);
    write_mode(1'b1);                            // switch to variance mode
    send_item(1'b0, VK_NULL_ARRAY, 24'sh0);
    send_item(1'b0, VK_DURATION, 24'sh000005);   // duration in variance mode fails
    for (int k = 4; k < 8; k++) begin
      send_item(1'b1, 3'd0, 24'sh0);
      send_item(1'b0, 3'(k), 24'sh0);            // unsupported and unknown codes
    end
    send_item(1'b1, 3'd7, 24'shFFFFFF);
  endtask

  task automatic test_random(input int count);
    int r;
    logic [2:0] vk;
    logic signed [23:0] s;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) idle_pct = 0;          // long stretch with no idling
      if (i == count / 2) idle_pct = 14;
      if (i % 200 == 199) write_mode(1'(~cur_mode));
      r = $urandom_range(99);
      if (r < 4) send_item(1'b1, 3'($urandom), 24'($urandom));
      else begin
        // mostly well-formed: stay within the current kind
        if (r < 10) vk = 3'($urandom);
        else if (kind_acc == KS_DUR && !cur_mode) vk = VK_DURATION;
        else if (kind_acc == KS_NONE && !cur_mode && r < 30) vk = VK_DURATION;
        else vk = r < 18 ? VK_NUM_NULL : VK_NUMBER;
        case ($urandom_range(3))
          0: s = 24'($urandom);
          1: s = 24'($signed($urandom_range(64)) - 32);
          2: s = $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
          default: s = 24'($signed($urandom_range(20000)) - 10000);
        endcase
        if (kind_acc == KS_FAILED && $urandom_range(3) != 0)
          send_item(1'b1, vk, s);
        else send_item(1'b0, vk, s);
      end
    end
  endtask

  // Stop sending until every outstanding beat has come back, then send one number
  task automatic test_full_drain();
    wait_drained();
    send_item(1'b0, VK_NUMBER, 24'sh000042);
  endtask

  initial begin
    cur_mode = 1'b0; mean_acc = '0; meansq_acc = '0; n_acc = '0; kind_acc = KS_NONE;
    mismatches = 0; results_seen = 0; items_sent = 0; idle_pct = 14;
    hold_quiet = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_full_drain();
    test_random(800);
    write_mode(1'b0);
    test_random(40);
    wait_drained();
    $display("sent %0d items, checked %0d result beats over both modes", items_sent,
             results_seen);
    $display("covered clear, null slots, all kind codes, failure latch, extreme samples");
    if (mismatches == 0 && expected_stats.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
`default_nettype wire
